/* hdl/dmc_pkg.sv */
// dmc_pkg: shared constants for the direct-mapped write-back cache core
// default geometry, byte width and request codes
// no dependencies
package dmc_pkg;

    localparam int DEF_NUM_LINES      = 64;
    localparam int DEF_BYTES_PER_LINE = 4;
    localparam int DEF_ADDR_BITS      = 16;

    localparam int BYTE_W = 8;

    // request type codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

endpackage

/* hdl/direct_mapped_writeback_cache_core.sv */
// direct_mapped_writeback_cache_core: top level of the write-back cache
// holds the access sequencer, the clearing sweep and the result register
// depends on dmc_pkg and dmc_ram
//
// usage
//   input channel (in_valid / in_stall) carries one request word: req_type,
//   byte_address and write_byte. a read request gives exactly one result
//   word on the output channel (out_valid / out_stall): read_byte, was_hit
//   and line_dirty. a write request gives no result word.
//   the line store (tag, data, valid, dirty per line) and the backing store
//   are both synchronous rams with registered read data; every access is
//   read, check, then, except for a read hit, write back into the line store.
//   a hit finishes in the lookup state (line read, then update or result).
//   a miss goes on to the fill state: the lookup also writes back a dirty
//   victim and reads the new block, the fill installs it.
//   the result word is registered and appears the cycle after the last
//   step; in_stall is low only between requests, so one request is in
//   flight at a time.
//   reset: both stores are swept to zero, one entry per cycle, over
//   max(2^ADDR_BITS / BYTES_PER_LINE, NUM_LINES) entries (16384 by default);
//   in_stall stays high until the sweep ends.
//   output stall: a pending result holds in its register; a read that
//   finishes while it is still held waits in place, keeping its line and
//   block reads steady, and in_stall stays high meanwhile.
//   NUM_LINES and BYTES_PER_LINE are powers of two, and the tag keeps at
//   least one bit.
module direct_mapped_writeback_cache_core
    import dmc_pkg::*;
#(
    parameter int NUM_LINES      = DEF_NUM_LINES,
    parameter int BYTES_PER_LINE = DEF_BYTES_PER_LINE,
    parameter int ADDR_BITS      = DEF_ADDR_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [ADDR_BITS-1:0] byte_address,
    input  logic [BYTE_W-1:0]    write_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    read_byte,
    output logic                 was_hit,
    output logic                 line_dirty
);

    // address split
    localparam int OFF_BITS  = $clog2(BYTES_PER_LINE);
    localparam int LINE_BITS = $clog2(NUM_LINES);
    localparam int TAG_BITS  = ADDR_BITS - LINE_BITS - OFF_BITS;
    localparam int WORD_BITS = ADDR_BITS - OFF_BITS;
    // clearing sweep covers whichever store is deeper
    localparam int CLR_BITS  = (WORD_BITS > LINE_BITS) ? WORD_BITS : LINE_BITS;

    // line store entry layout: {valid, dirty, tag, data}
    localparam int LINE_W    = BYTES_PER_LINE * BYTE_W;
    localparam int ENT_W     = 2 + TAG_BITS + LINE_W;
    localparam int ENT_VALID = ENT_W - 1;
    localparam int ENT_DIRTY = ENT_W - 2;

    // sequencer states
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_FILL   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CLR_BITS-1:0] clr_cnt_reg, clr_cnt_next;

    // captured request
    logic                 req_write_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [LINE_BITS-1:0] line_reg;
    logic [OFF_BITS-1:0]  off_reg;
    logic [BYTE_W-1:0]    wbyte_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_hit_reg;
    logic              out_dirty_reg;

    // ram ports
    logic                 line_we;
    logic [LINE_BITS-1:0] line_waddr;
    logic [ENT_W-1:0]     line_wdata;
    logic [LINE_BITS-1:0] line_raddr;
    logic [ENT_W-1:0]     line_rdata;

    logic                 back_we;
    logic [WORD_BITS-1:0] back_waddr;
    logic [LINE_W-1:0]    back_wdata;
    logic [WORD_BITS-1:0] back_raddr;
    logic [LINE_W-1:0]    back_rdata;

    logic                in_take;
    logic                out_free;
    logic                out_load;
    logic                ent_valid;
    logic                ent_dirty;
    logic [TAG_BITS-1:0] ent_tag;
    logic [LINE_W-1:0]   ent_data;
    logic                hit;
    logic [LINE_W-1:0]   base_data;
    logic [LINE_W-1:0]   merged_data;
    logic [BYTE_W-1:0]   sel_byte;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    // result register can take a new word this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // line store entry fields as read back in the lookup cycle
    assign ent_valid = line_rdata[ENT_VALID];
    assign ent_dirty = line_rdata[ENT_DIRTY];
    assign ent_tag   = line_rdata[LINE_W +: TAG_BITS];
    assign ent_data  = line_rdata[LINE_W-1:0];
    assign hit       = ent_valid && (ent_tag == tag_reg);

    // line data the access works on: stored line on a hit, new block on a fill
    assign base_data = (state_reg == ST_FILL) ? back_rdata : ent_data;
    assign sel_byte  = base_data[off_reg*BYTE_W +: BYTE_W];

    always_comb
    begin
        merged_data = base_data;
        for (int i = 0; i < BYTES_PER_LINE; i++)
        begin
            if (OFF_BITS'(i) == off_reg)
            begin
                merged_data[i*BYTE_W +: BYTE_W] = wbyte_reg;
            end
        end
    end

    // read addresses: the line index straight from the request when idle,
    // then held so a waiting access keeps its read data
    assign line_raddr = (state_reg == ST_IDLE) ? byte_address[OFF_BITS +: LINE_BITS] : line_reg;
    assign back_raddr = {tag_reg, line_reg};

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        out_load     = 1'b0;
        line_we      = 1'b0;
        line_waddr   = line_reg;
        line_wdata   = {1'b1, 1'b1, tag_reg, merged_data};
        back_we      = 1'b0;
        back_waddr   = {ent_tag, line_reg};
        back_wdata   = ent_data;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero both stores, one word per cycle
                line_we      = 1'b1;
                line_waddr   = clr_cnt_reg[LINE_BITS-1:0];
                line_wdata   = '0;
                back_we      = 1'b1;
                back_waddr   = clr_cnt_reg[WORD_BITS-1:0];
                back_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (hit)
                begin
                    if (req_write_reg == REQ_WRITE)
                    begin
                        line_we    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        // read hit changes nothing in the store
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // miss: write back a dirty victim, fetch the new block
                    back_we    = ent_valid && ent_dirty;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (req_write_reg == REQ_WRITE)
                begin
                    line_we    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    // installed clean
                    line_we    = 1'b1;
                    line_wdata = {1'b1, 1'b0, tag_reg, back_rdata};
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_write_reg <= req_type;
            tag_reg       <= byte_address[OFF_BITS + LINE_BITS +: TAG_BITS];
            line_reg      <= byte_address[OFF_BITS +: LINE_BITS];
            off_reg       <= byte_address[OFF_BITS-1:0];
            wbyte_reg     <= write_byte;
        end
    end

    // result payload; a fill result always reports miss and clean
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg  <= sel_byte;
            out_hit_reg   <= (state_reg == ST_LOOKUP);
            out_dirty_reg <= (state_reg == ST_LOOKUP) && ent_dirty;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_byte  = out_byte_reg;
    assign was_hit    = out_hit_reg;
    assign line_dirty = out_dirty_reg;

    // per-line tag, data, valid and dirty
    dmc_ram #(
        .DEPTH_BITS (LINE_BITS),
        .WIDTH      (ENT_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // backing memory, one line-sized word per block
    dmc_ram #(
        .DEPTH_BITS (WORD_BITS),
        .WIDTH      (LINE_W)
    ) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    // an accepted request always goes to lookup next
    a_take_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    // a hit never goes on to a fill
    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && hit) |=> (state_reg != ST_FILL))
        else $error("hit went to fill");

    // a result loaded from a fill reports a clean miss
    a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && out_load) |=> (out_valid_reg && !out_hit_reg && !out_dirty_reg))
        else $error("fill result not a clean miss");

    // the backing store is only written in the sweep or at a miss lookup
    a_back_write: assert property (@(posedge clk) disable iff (!rst_n)
        back_we |-> (state_reg == ST_CLEAR || (state_reg == ST_LOOKUP && !hit)))
        else $error("backing store written outside sweep or writeback");

    // a read result is never loaded over an unread, stalled word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("result word overwritten while stalled");

endmodule

/* hdl/dmc_ram.sv */
// dmc_ram: simple dual-port synchronous ram, one write and one read port
// read data is registered
// no dependencies
module dmc_ram #(
    parameter int DEPTH_BITS = 6,
    parameter int WIDTH      = 32
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [DEPTH_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [DEPTH_BITS-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    localparam int DEPTH = 1 << DEPTH_BITS;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* tb/tb_direct_mapped_writeback_cache_core.sv */
// tb_direct_mapped_writeback_cache_core: self-checking bench for the write-back cache core
// directed table then random traffic, every read word checked against its typed row or a local cache model
// depends on dmc_pkg and direct_mapped_writeback_cache_core
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache_core
    import dmc_pkg::*;
();

    // geometry taken from the package defaults, same as the dut instance
    localparam int NL       = DEF_NUM_LINES;
    localparam int BPL      = DEF_BYTES_PER_LINE;
    localparam int AB       = DEF_ADDR_BITS;
    localparam int MEM_SIZE = 1 << AB;
    localparam int TAG_SPAN = NL * BPL;
    localparam int TAG_MAX  = MEM_SIZE / TAG_SPAN - 1;

    localparam int RANDOM_WORDS  = 1880;
    localparam int STALL_LIMIT   = 100000;  // covers the clearing sweep after reset
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_PERCENT  = 29;

    // one read result word
    typedef struct packed {
        bit [BYTE_W-1:0] rd_byte;
        bit              hit;
        bit              dirty;
    } read_word_t;

    // one row of the directed table; typed rows carry their own expected word
    typedef struct packed {
        bit              kind;
        bit [AB-1:0]     addr;
        bit [BYTE_W-1:0] data;
        bit              typed;
        read_word_t      want;
    } dir_row_t;

    localparam read_word_t NO_WANT = '0;
    localparam int DIR_ROWS = 22;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // cold reads after reset: zero data, miss, clean
        '{REQ_READ,  16'h0000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{REQ_READ,  16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        // write hit then read back dirty
        '{REQ_WRITE, 16'h0001, 8'hFF, 1'b0, NO_WANT},
        '{REQ_READ,  16'h0001, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        // conflict on line 0 evicts the dirty line, then refetch sees the writeback
        '{REQ_READ,  16'h0101, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{REQ_READ,  16'h0001, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        // top line: write hit, then write miss with dirty victim (write-allocate)
        '{REQ_WRITE, 16'hFFFF, 8'hA5, 1'b0, NO_WANT},
        '{REQ_WRITE, 16'h00FF, 8'h5A, 1'b0, NO_WANT},
        '{REQ_READ,  16'h00FF, 8'h00, 1'b1, '{8'h5A, 1'b1, 1'b1}},
        '{REQ_READ,  16'hFFFF, 8'h00, 1'b1, '{8'hA5, 1'b0, 1'b0}},
        // write miss into a never-used line, neighbor byte stays zero
        '{REQ_WRITE, 16'h5555, 8'h00, 1'b0, NO_WANT},
        '{REQ_READ,  16'h5554, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
        // alternating bit patterns on the address, then patterns around the top bit
        '{REQ_WRITE, 16'hAAAA, 8'hFF, 1'b0, NO_WANT},
        '{REQ_READ,  16'hAAAA, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 16'hAAAB, 8'h01, 1'b0, NO_WANT},
        '{REQ_READ,  16'h2AAA, 8'hFF, 1'b0, NO_WANT},
        '{REQ_READ,  16'hAAAB, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 16'h8003, 8'h80, 1'b0, NO_WANT},
        '{REQ_WRITE, 16'h8003, 8'h7F, 1'b0, NO_WANT},
        '{REQ_READ,  16'h8003, 8'h00, 1'b0, NO_WANT},
        '{REQ_READ,  16'h7FFC, 8'h00, 1'b0, NO_WANT},
        '{REQ_READ,  16'h0000, 8'h00, 1'b0, NO_WANT}
    };

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // dut inputs, all known from time zero
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic              req_type     = REQ_READ;
    logic [AB-1:0]     byte_address = '0;
    logic [BYTE_W-1:0] write_byte   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [BYTE_W-1:0] read_byte;
    logic              was_hit;
    logic              line_dirty;

    direct_mapped_writeback_cache_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .byte_address (byte_address),
        .write_byte   (write_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_byte    (read_byte),
        .was_hit      (was_hit),
        .line_dirty   (line_dirty)
    );

    // local copy of the cache and its backing memory, all zero like the dut after reset
    bit [BYTE_W-1:0] line_data [NL][BPL];
    int unsigned     line_tag  [NL];
    bit              line_vld  [NL];
    bit              line_mod  [NL];
    bit [BYTE_W-1:0] mem_image [MEM_SIZE];

    read_word_t pending_reads [$];    // read words still owed by the dut
    int         mismatches = 0;
    bit         steady     = 1'b0;    // when set neither side idles

    // applies one access to the local cache; returns 1 when a read word results
    function automatic bit cache_access(input bit kind, input bit [AB-1:0] addr,
                                        input bit [BYTE_W-1:0] data, output read_word_t rw);
        int unsigned a;
        int unsigned off;
        int unsigned ln;
        int unsigned tg;
        int unsigned victim;
        int unsigned blk;
        bit          hit;
        a   = addr;
        off = a % BPL;
        ln  = (a / BPL) % NL;
        tg  = a / TAG_SPAN;
        hit = line_vld[ln] && line_tag[ln] == tg;
        rw  = '0;
        if (!hit)
        begin
            // dirty victim goes back to memory before the fill
            if (line_vld[ln] && line_mod[ln])
            begin
                victim = (line_tag[ln] * NL + ln) * BPL;
                for (int i = 0; i < BPL; i++)
                    mem_image[(victim + i) % MEM_SIZE] = line_data[ln][i];
            end
            blk = a - off;
            for (int i = 0; i < BPL; i++)
                line_data[ln][i] = mem_image[(blk + i) % MEM_SIZE];
            line_tag[ln] = tg;
            line_vld[ln] = 1'b1;
            line_mod[ln] = 1'b0;
        end
        if (kind == REQ_WRITE)
        begin
            line_data[ln][off] = data;
            line_mod[ln]       = 1'b1;
            return 1'b0;
        end
        rw.rd_byte = line_data[ln][off];
        rw.hit     = hit;
        rw.dirty   = line_mod[ln];
        return 1'b1;
    endfunction

    // presents one request word, holds it until taken, then updates the model
    task automatic send_request(input bit kind, input bit [AB-1:0] addr,
                                input bit [BYTE_W-1:0] data, input bit typed,
                                input read_word_t want);
        read_word_t rw;
        // random gap before the word
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        byte_address <= addr;
        write_byte   <= data;
        do
            @(posedge clk);
        while (in_stall);
        if (cache_access(kind, addr, data, rw))
            pending_reads.push_back(typed ? want : rw);
    endtask

    // sender holds off until every owed read word has arrived
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reads.size() != 0);
    endtask

    // receiver side: random stall, none in the steady stretch
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);

    // result checker: each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        read_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected read word: byte %02h hit %0b dirty %0b",
                             read_byte, was_hit, line_dirty);
            end
            else
            begin
                exp_w = pending_reads.pop_front();
                if (read_byte !== exp_w.rd_byte || was_hit !== exp_w.hit
                    || line_dirty !== exp_w.dirty)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch (byte hit dirty): expected %02h %0b %0b, got %02h %0b %0b",
                                 exp_w.rd_byte, exp_w.hit, exp_w.dirty,
                                 read_byte, was_hit, line_dirty);
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int unsigned     tag_pool  [3];
        int unsigned     line_pool [4];
        int unsigned     tg;
        int unsigned     ln;
        bit              kind;
        bit [AB-1:0]     addr;
        bit [BYTE_W-1:0] data;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; the dut holds in_stall through its clearing sweep
        for (int r = 0; r < DIR_ROWS; r++)
            send_request(DIRECTED[r].kind, DIRECTED[r].addr, DIRECTED[r].data,
                         DIRECTED[r].typed, DIRECTED[r].want);
        wait_for_results();

        // random traffic: small pools of tags and lines give hits, conflicts and evictions
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 200 == 0)
            begin
                foreach (tag_pool[i])
                    tag_pool[i] = $urandom_range(TAG_MAX);
                foreach (line_pool[i])
                    line_pool[i] = $urandom_range(NL - 1);
            end
            steady = (n >= 700 && n < 1000);
            if (n == 1200)
                wait_for_results();

            if ($urandom_range(99) < 85)
            begin
                tg = tag_pool[$urandom_range(2)];
                ln = ($urandom_range(9) < 7) ? line_pool[$urandom_range(3)]
                                             : $urandom_range(NL - 1);
                addr = AB'((tg * NL + ln) * BPL + $urandom_range(BPL - 1));
            end
            else
                addr = AB'($urandom_range(MEM_SIZE - 1));

            kind = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_READ;
            case ($urandom_range(9))
                0:       data = '0;
                1:       data = '1;
                default: data = BYTE_W'($urandom_range(255));
            endcase
            send_request(kind, addr, data, 1'b0, NO_WANT);
        end
        steady = 1'b0;

        // drain and let the last access settle
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
hdl/dmc_pkg.sv
hdl/dmc_ram.sv
hdl/direct_mapped_writeback_cache_core.sv
tb/tb_direct_mapped_writeback_cache_core.sv
